// ===== rtl/rrq_pkg.sv =====
// ---------------------------------------------------------------------------
// rrq_pkg
// shared sizes, codes and types of the record ring queue
// ---------------------------------------------------------------------------
package rrq_pkg;

  localparam int QUEUE_BYTES    = 256;
  localparam int MAX_DATA_BYTES = 8;
  localparam int HEADER_BYTES   = 3;

  // fixed by the beat format
  localparam int DATA_SLOTS = 8;
  localparam int LEN_OUT_W  = 4;
  localparam int STEP_W     = 4;

  localparam int PTR_W = $clog2(QUEUE_BYTES);
  localparam int CNT_W = $clog2(QUEUE_BYTES + 1);
  localparam int SUM_W = $clog2(QUEUE_BYTES + HEADER_BYTES + 256);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_BOUNDS   = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic                           opcode;
    logic [7:0]                     rec_type;
    logic [7:0]                     rec_node;
    logic [7:0]                     rec_length;
    logic [DATA_SLOTS-1:0][7:0]     data;
  } rrq_req_t;

  typedef struct packed {
    logic [1:0]                     status;
    logic [7:0]                     out_type;
    logic [7:0]                     out_node;
    logic [LEN_OUT_W-1:0]           out_length;
    logic [DATA_SLOTS-1:0][7:0]     out_data;
  } rrq_res_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } rrq_mem_req_t;

  // ring pointer advance with wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(QUEUE_BYTES - 1)) begin
      res = '0;
    end else begin
      res = ptr + PTR_W'(1);
    end
    return res;
  endfunction

endpackage

// ===== rtl/rrq_in_if.sv =====
// ---------------------------------------------------------------------------
// rrq_in_if
// request channel of the record ring queue
// ---------------------------------------------------------------------------
interface rrq_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rec_type;
  logic [7:0] rec_node;
  logic [7:0] rec_length;
  logic [7:0] data0;
  logic [7:0] data1;
  logic [7:0] data2;
  logic [7:0] data3;
  logic [7:0] data4;
  logic [7:0] data5;
  logic [7:0] data6;
  logic [7:0] data7;

  modport source (
    output valid, opcode, rec_type, rec_node, rec_length,
    output data0, data1, data2, data3, data4, data5, data6, data7,
    input  ready
  );
  modport sink (
    input  valid, opcode, rec_type, rec_node, rec_length,
    input  data0, data1, data2, data3, data4, data5, data6, data7,
    output ready
  );
endinterface

// ===== rtl/rrq_out_if.sv =====
// ---------------------------------------------------------------------------
// rrq_out_if
// result channel of the record ring queue
// ---------------------------------------------------------------------------
interface rrq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_type;
  logic [7:0] out_node;
  logic [3:0] out_length;
  logic [7:0] out_data0;
  logic [7:0] out_data1;
  logic [7:0] out_data2;
  logic [7:0] out_data3;
  logic [7:0] out_data4;
  logic [7:0] out_data5;
  logic [7:0] out_data6;
  logic [7:0] out_data7;

  modport source (
    output valid, status, out_type, out_node, out_length,
    output out_data0, out_data1, out_data2, out_data3,
    output out_data4, out_data5, out_data6, out_data7,
    input  ready
  );
  modport sink (
    input  valid, status, out_type, out_node, out_length,
    input  out_data0, out_data1, out_data2, out_data3,
    input  out_data4, out_data5, out_data6, out_data7,
    output ready
  );
endinterface

// ===== rtl/record_ring_queue.sv =====
// ---------------------------------------------------------------------------
// record_ring_queue
// byte-wide ring buffer of length-prefixed records
// ---------------------------------------------------------------------------
// usage:
//   in_ch carries one request beat: opcode 0 appends a record (type, node,
//   length header plus rec_length data bytes), opcode 1 removes the oldest
//   record. every request beat gives exactly one result beat on out_ch,
//   with status ok, overflow, bounds or empty; fields other than status are
//   zero unless a record is returned.
// timing:
//   the sequencer moves one byte per cycle through a single ring ram: a
//   write stores the three header bytes and then the data bytes, and a
//   read issues each ram read ahead of the byte it takes. a request
//   refused at intake goes straight to the result, a read refused for its
//   stored length once its length byte is read. the result passes the
//   done state to the output register. only one request is handled at a time.
// stall:
//   the output register holds a finished result while out_ch is stalled;
//   the sequencer can take and process the next request meanwhile and then
//   waits with its result until the output register frees up.
// reset:
//   rst_n (synchronous, active low) empties the queue: head, tail and count
//   go to zero. ram contents are not cleared and are never read unwritten.
// ---------------------------------------------------------------------------
module record_ring_queue import rrq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rrq_in_if.sink    in_ch,
  rrq_out_if.source out_ch
);

  rrq_req_t     req;
  rrq_res_t     res;
  rrq_mem_req_t mem_req;
  logic [7:0]   mem_rdata;
  logic         res_valid;
  logic         res_ready;

  // output register
  logic         out_vld_r, out_vld_nxt;
  rrq_res_t     out_res_r;

  // gather the request beat
  assign req.opcode     = in_ch.opcode;
  assign req.rec_type   = in_ch.rec_type;
  assign req.rec_node   = in_ch.rec_node;
  assign req.rec_length = in_ch.rec_length;
  assign req.data[0]    = in_ch.data0;
  assign req.data[1]    = in_ch.data1;
  assign req.data[2]    = in_ch.data2;
  assign req.data[3]    = in_ch.data3;
  assign req.data[4]    = in_ch.data4;
  assign req.data[5]    = in_ch.data5;
  assign req.data[6]    = in_ch.data6;
  assign req.data[7]    = in_ch.data7;

  rrq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_req    (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // the record bytes themselves
  rrq_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // take a result whenever the output register is empty or being drained
  assign res_ready = !out_vld_r || out_ch.ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_valid && res_ready) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.status     = out_res_r.status;
  assign out_ch.out_type   = out_res_r.out_type;
  assign out_ch.out_node   = out_res_r.out_node;
  assign out_ch.out_length = out_res_r.out_length;
  assign out_ch.out_data0  = out_res_r.out_data[0];
  assign out_ch.out_data1  = out_res_r.out_data[1];
  assign out_ch.out_data2  = out_res_r.out_data[2];
  assign out_ch.out_data3  = out_res_r.out_data[3];
  assign out_ch.out_data4  = out_res_r.out_data[4];
  assign out_ch.out_data5  = out_res_r.out_data[5];
  assign out_ch.out_data6  = out_res_r.out_data[6];
  assign out_ch.out_data7  = out_res_r.out_data[7];

endmodule

// ===== rtl/rrq_ram.sv =====
// ---------------------------------------------------------------------------
// rrq_ram
// generic one-write one-read ram with registered read data
// ---------------------------------------------------------------------------
module rrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rrq_engine.sv =====
// ---------------------------------------------------------------------------
// rrq_engine
// byte sequencer: checks a request, then moves its bytes through the ring ram
// ---------------------------------------------------------------------------
module rrq_engine import rrq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  rrq_req_t     in_req,
  output logic         res_valid,
  input  logic         res_ready,
  output rrq_res_t     res,
  output rrq_mem_req_t mem_req,
  input  logic [7:0]   mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WRITE = 4'b0010,
    S_READ  = 4'b0100,
    S_DONE  = 4'b1000
  } rrq_state_t;

  rrq_state_t          state_r, state_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [PTR_W-1:0]    addr_r, addr_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [LEN_OUT_W-1:0] rlen_r, rlen_nxt;
  rrq_req_t            req_r, req_nxt;
  rrq_res_t            res_r, res_nxt;

  logic [SUM_W-1:0]    fill_sum;
  logic [SUM_W-1:0]    need_sum;
  logic [STEP_W-1:0]   last_wr;
  logic [STEP_W-1:0]   didx_full;
  logic [2:0]          didx;

  assign fill_sum  = SUM_W'(count_r) + SUM_W'(HEADER_BYTES) + SUM_W'(in_req.rec_length);
  assign need_sum  = SUM_W'(mem_rdata) + SUM_W'(HEADER_BYTES);
  assign last_wr   = STEP_W'(req_r.rec_length[LEN_OUT_W-1:0]) + STEP_W'(HEADER_BYTES - 1);
  assign didx_full = step_r - STEP_W'(HEADER_BYTES);
  assign didx      = didx_full[2:0];

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    addr_nxt   = addr_r;
    step_nxt   = step_r;
    rd_vld_nxt = rd_vld_r;
    rlen_nxt   = rlen_r;
    req_nxt    = req_r;
    res_nxt    = res_r;

    mem_req       = '0;
    mem_req.waddr = addr_r;
    mem_req.raddr = addr_r;
    case (step_r)
      STEP_W'(0): mem_req.wdata = req_r.rec_type;
      STEP_W'(1): mem_req.wdata = req_r.rec_node;
      STEP_W'(2): mem_req.wdata = req_r.rec_length;
      default:    mem_req.wdata = req_r.data[didx];
    endcase

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_req;
          res_nxt    = '0;
          step_nxt   = '0;
          rd_vld_nxt = 1'b0;
          if (in_req.opcode == OP_WRITE) begin
            addr_nxt = head_r;
            if (fill_sum > SUM_W'(QUEUE_BYTES)) begin
              res_nxt.status = ST_OVERFLOW;
              state_nxt      = S_DONE;
            end else if (in_req.rec_length > 8'(MAX_DATA_BYTES)) begin
              res_nxt.status = ST_BOUNDS;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_WRITE;
            end
          end else begin
            addr_nxt = tail_r;
            if (count_r == '0) begin
              res_nxt.status = ST_EMPTY;
              state_nxt      = S_DONE;
            end else if (count_r < CNT_W'(HEADER_BYTES)) begin
              res_nxt.status = ST_BOUNDS;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_WRITE: begin
        mem_req.we = 1'b1;
        addr_nxt   = ptr_inc(addr_r);
        step_nxt   = step_r + STEP_W'(1);
        if (step_r == last_wr) begin
          head_nxt  = ptr_inc(addr_r);
          count_nxt = count_r + CNT_W'(req_r.rec_length) + CNT_W'(HEADER_BYTES);
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        // one read issued ahead of the byte being taken
        mem_req.re = 1'b1;
        addr_nxt   = ptr_inc(addr_r);
        rd_vld_nxt = 1'b1;
        if (rd_vld_r) begin
          step_nxt = step_r + STEP_W'(1);
          if (step_r == STEP_W'(0)) begin
            res_nxt.out_type = mem_rdata;
          end else if (step_r == STEP_W'(1)) begin
            res_nxt.out_node = mem_rdata;
          end else if (step_r == STEP_W'(2)) begin
            if (mem_rdata > 8'(MAX_DATA_BYTES) || SUM_W'(count_r) < need_sum) begin
              res_nxt        = '0;
              res_nxt.status = ST_BOUNDS;
              state_nxt      = S_DONE;
            end else begin
              res_nxt.out_length = mem_rdata[LEN_OUT_W-1:0];
              rlen_nxt           = mem_rdata[LEN_OUT_W-1:0];
              if (mem_rdata == '0) begin
                tail_nxt  = addr_r;
                count_nxt = count_r - CNT_W'(HEADER_BYTES);
                state_nxt = S_DONE;
              end
            end
          end else begin
            res_nxt.out_data[didx] = mem_rdata;
            if (step_r == STEP_W'(rlen_r) + STEP_W'(HEADER_BYTES - 1)) begin
              tail_nxt  = addr_r;
              count_nxt = count_r - CNT_W'(step_r) - CNT_W'(1);
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= rd_vld_nxt;
      step_r   <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    rlen_r <= rlen_nxt;
    req_r  <= req_nxt;
    res_r  <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_BYTES))
    else $error("byte count above capacity");

  a_err_keeps_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) != S_DONE && state_r == S_DONE && res_r.status != ST_OK)
      |-> ($stable(head_r) && $stable(tail_r) && $stable(count_r)))
    else $error("refused beat moved a pointer");

  a_read_frees: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_READ && state_r == S_DONE && res_r.status == ST_OK)
      |-> (count_r < $past(count_r)))
    else $error("successful read freed no bytes");

  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res_r.out_length <= LEN_OUT_W'(MAX_DATA_BYTES)))
    else $error("returned length above data maximum");
`endif

endmodule

// ===== sim/rrq_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrq_checker
// watches the request and result channels of the record ring queue, keeps
// its own copy of the ring and compares every result beat field by field
// ---------------------------------------------------------------------------
module rrq_checker import rrq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rrq_in_if           in_ch,
  rrq_out_if          out_ch,
  output int unsigned mismatches,
  output int unsigned replies_owed
);

  logic [7:0]  ring_mem [QUEUE_BYTES];
  int unsigned wr_pos;
  int unsigned rd_pos;
  int unsigned bytes_held;
  rrq_res_t    owed_replies [$];
  int unsigned fault_tally = 0;
  int unsigned owed_now    = 0;

  assign mismatches   = fault_tally;
  assign replies_owed = owed_now;

  function automatic int unsigned ring_at(input int unsigned base, input int unsigned off);
    return (base + off) % QUEUE_BYTES;
  endfunction

  // applies one request to the ring copy and returns the reply it owes
  function automatic rrq_res_t ring_response(input rrq_req_t req);
    rrq_res_t    res;
    int unsigned len;
    int unsigned i;
    res = '0;
    if (req.opcode == OP_WRITE) begin
      len = 32'(req.rec_length);
      if (bytes_held + HEADER_BYTES + len > QUEUE_BYTES) begin
        res.status = ST_OVERFLOW;
      end else if (len > MAX_DATA_BYTES) begin
        res.status = ST_BOUNDS;
      end else begin
        ring_mem[wr_pos]             = req.rec_type;
        ring_mem[ring_at(wr_pos, 1)] = req.rec_node;
        ring_mem[ring_at(wr_pos, 2)] = req.rec_length;
        for (i = 0; i < len; i++) begin
          ring_mem[ring_at(wr_pos, HEADER_BYTES + i)] = req.data[i];
        end
        wr_pos     = ring_at(wr_pos, HEADER_BYTES + len);
        bytes_held = bytes_held + HEADER_BYTES + len;
        res.status = ST_OK;
      end
    end else if (bytes_held == 0) begin
      res.status = ST_EMPTY;
    end else if (bytes_held < HEADER_BYTES) begin
      res.status = ST_BOUNDS;
    end else begin
      len = 32'(ring_mem[ring_at(rd_pos, 2)]);
      if (len > MAX_DATA_BYTES || bytes_held < len + HEADER_BYTES) begin
        // tail stays where it is
        res.status = ST_BOUNDS;
      end else begin
        res.status     = ST_OK;
        res.out_type   = ring_mem[rd_pos];
        res.out_node   = ring_mem[ring_at(rd_pos, 1)];
        res.out_length = LEN_OUT_W'(len);
        for (i = 0; i < len; i++) begin
          res.out_data[i] = ring_mem[ring_at(rd_pos, HEADER_BYTES + i)];
        end
        rd_pos     = ring_at(rd_pos, HEADER_BYTES + len);
        bytes_held = bytes_held - (HEADER_BYTES + len);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] rrq_checker: %s", $time, msg);
    fault_tally++;
  endtask

  task automatic check_beat(input rrq_res_t want);
    logic [DATA_SLOTS-1:0][7:0] got_data;
    int i;
    got_data = {out_ch.out_data7, out_ch.out_data6, out_ch.out_data5, out_ch.out_data4,
                out_ch.out_data3, out_ch.out_data2, out_ch.out_data1, out_ch.out_data0};
    if (out_ch.status !== want.status) begin
      report_mismatch($sformatf("status got %0d want %0d", out_ch.status, want.status));
    end
    if (out_ch.out_type !== want.out_type) begin
      report_mismatch($sformatf("out_type got %0h want %0h", out_ch.out_type, want.out_type));
    end
    if (out_ch.out_node !== want.out_node) begin
      report_mismatch($sformatf("out_node got %0h want %0h", out_ch.out_node, want.out_node));
    end
    if (out_ch.out_length !== want.out_length) begin
      report_mismatch($sformatf("out_length got %0d want %0d",
                                out_ch.out_length, want.out_length));
    end
    for (i = 0; i < DATA_SLOTS; i++) begin
      if (got_data[i] !== want.out_data[i]) begin
        report_mismatch($sformatf("out_data%0d got %0h want %0h",
                                  i, got_data[i], want.out_data[i]));
      end
    end
  endtask

  always @(posedge clk) begin : watch
    rrq_req_t req;
    if (!rst_n) begin
      wr_pos     = 0;
      rd_pos     = 0;
      bytes_held = 0;
      owed_replies.delete();
    end else begin
      // result first: a reply never leaves on the edge its request enters
      if (out_ch.valid && out_ch.ready) begin
        if (owed_replies.size() == 0) begin
          report_mismatch("result beat with no request waiting for it");
        end else begin
          check_beat(owed_replies.pop_front());
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        req.opcode     = in_ch.opcode;
        req.rec_type   = in_ch.rec_type;
        req.rec_node   = in_ch.rec_node;
        req.rec_length = in_ch.rec_length;
        req.data       = {in_ch.data7, in_ch.data6, in_ch.data5, in_ch.data4,
                          in_ch.data3, in_ch.data2, in_ch.data1, in_ch.data0};
        owed_replies.push_back(ring_response(req));
      end
    end
    owed_now = owed_replies.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// drives requests into the record ring queue and stalls its result channel;
// a directed opening hits empty reads, refused writes and extreme records,
// then random phases swing the ring between empty and full
// ---------------------------------------------------------------------------
module testbench;
  import rrq_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 30;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // 2 ns period
  always #1 clk = ~clk;

  rrq_in_if  req_bus ();
  rrq_out_if res_bus ();

  int unsigned mismatches;
  int unsigned replies_owed;
  int unsigned cycles    = 0;
  bit          src_calm  = 1'b0;  // sender offers back to back
  bit          sink_calm = 1'b0;  // receiver takes every beat at once
  bit          sink_hold = 1'b0;  // receiver refuses everything

  record_ring_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_bus),
    .out_ch (res_bus)
  );

  rrq_checker ring_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (req_bus),
    .out_ch       (res_bus),
    .mismatches   (mismatches),
    .replies_owed (replies_owed)
  );

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic rrq_req_t make_record(input logic op, input logic [7:0] ty,
                                           input logic [7:0] nd, input logic [7:0] ln,
                                           input logic [63:0] payload);
    rrq_req_t r;
    r.opcode     = op;
    r.rec_type   = ty;
    r.rec_node   = nd;
    r.rec_length = ln;
    r.data       = payload;
    return r;
  endfunction

  // one request beat: random gap, then hold valid until the block takes it
  task automatic send_record(input rrq_req_t r);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      req_bus.valid <= 1'b0;
    end
    @(negedge clk);
    req_bus.valid      <= 1'b1;
    req_bus.opcode     <= r.opcode;
    req_bus.rec_type   <= r.rec_type;
    req_bus.rec_node   <= r.rec_node;
    req_bus.rec_length <= r.rec_length;
    req_bus.data0      <= r.data[0];
    req_bus.data1      <= r.data[1];
    req_bus.data2      <= r.data[2];
    req_bus.data3      <= r.data[3];
    req_bus.data4      <= r.data[4];
    req_bus.data5      <= r.data[5];
    req_bus.data6      <= r.data[6];
    req_bus.data7      <= r.data[7];
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // stop offering and wait until every reply is back
  task automatic await_drain();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (replies_owed != 0) @(negedge clk);
  endtask

  // receiver: unless sink_calm is set, draws a random stall after each result beat
  initial begin : result_sink
    int unsigned wait_left;
    wait_left     = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res_bus.valid && res_bus.ready && !sink_calm) begin
        wait_left = $urandom_range(0, 10);
      end
      @(negedge clk);
      if (sink_hold) begin
        res_bus.ready <= 1'b0;
      end else if (wait_left > 0) begin
        res_bus.ready <= 1'b0;
        wait_left--;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_no;
    int unsigned phase_len;
    int unsigned write_pct;
    rrq_req_t    r;

    req_bus.valid      = 1'b0;
    req_bus.opcode     = OP_WRITE;
    req_bus.rec_type   = '0;
    req_bus.rec_node   = '0;
    req_bus.rec_length = '0;
    req_bus.data0      = '0;
    req_bus.data1      = '0;
    req_bus.data2      = '0;
    req_bus.data3      = '0;
    req_bus.data4      = '0;
    req_bus.data5      = '0;
    req_bus.data6      = '0;
    req_bus.data7      = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed opening
    send_record(make_record(OP_READ, 8'h00, 8'h00, 8'h00, 64'h0));  // read of empty ring
    send_record(make_record(OP_WRITE, 8'h00, 8'h00, 8'd0, 64'h0));  // header only record
    send_record(make_record(OP_WRITE, 8'hff, 8'hff, 8'd8, {8{8'hff}}));  // longest record
    send_record(make_record(OP_WRITE, 8'h5a, 8'ha5, 8'd1, 64'h0123_4567_89ab_cdef));
    send_record(make_record(OP_READ, 8'hff, 8'hff, 8'hff, {8{8'hff}}));  // read ignores fields
    send_record(make_record(OP_READ, 8'h00, 8'h00, 8'h00, 64'h0));
    send_record(make_record(OP_READ, 8'h00, 8'h00, 8'h00, 64'h0));
    send_record(make_record(OP_READ, 8'h00, 8'h00, 8'h00, 64'h0));  // empty again
    // refused writes: length over the data limit, and record bigger than the ring
    send_record(make_record(OP_WRITE, 8'h11, 8'h22, 8'd9, {8{8'h33}}));
    send_record(make_record(OP_WRITE, 8'h11, 8'h22, 8'd128, {8{8'h44}}));
    send_record(make_record(OP_WRITE, 8'h11, 8'h22, 8'd253, {8{8'h55}}));
    send_record(make_record(OP_WRITE, 8'h11, 8'h22, 8'd254, {8{8'h66}}));
    send_record(make_record(OP_WRITE, 8'h11, 8'h22, 8'd255, {8{8'h77}}));
    send_record(make_record(OP_READ, 8'h00, 8'h00, 8'h00, 64'h0));  // nothing was stored
    send_record(make_record(OP_WRITE, 8'h80, 8'h01, 8'd7, 64'h8070_6050_4030_2010));
    send_record(make_record(OP_WRITE, 8'h01, 8'h80, 8'd3, 64'hfedc_ba98_7654_3210));
    send_record(make_record(OP_WRITE, 8'haa, 8'h55, 8'd8, 64'h55aa_55aa_55aa_55aa));
    send_record(make_record(OP_READ, 8'h00, 8'h00, 8'h00, 64'h0));
    send_record(make_record(OP_READ, 8'h00, 8'h00, 8'h00, 64'h0));
    send_record(make_record(OP_READ, 8'h00, 8'h00, 8'h00, 64'h0));
    send_record(make_record(OP_READ, 8'h00, 8'h00, 8'h00, 64'h0));
    await_drain();

    // random phases, each with its own write bias so the ring fills and empties
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 150);
      case ($urandom_range(0, 3))
        0:       write_pct = 20;
        1:       write_pct = 50;
        2:       write_pct = 75;
        default: write_pct = 90;
      endcase
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      // long receiver hold-off while requests keep coming back to back
      if (phase_no == 1 || phase_no == 6) begin
        src_calm = 1'b1;
        fork
          begin
            @(posedge clk);
            sink_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            sink_hold = 1'b0;
          end
        join_none
      end
      repeat (phase_len) begin
        r.opcode     = ($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_READ;
        r.rec_type   = 8'($urandom);
        r.rec_node   = 8'($urandom);
        // mostly legal lengths, now and then anything the field can hold
        r.rec_length = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, MAX_DATA_BYTES))
                                                    : 8'($urandom_range(0, 255));
        r.data       = {$urandom, $urandom};
        send_record(r);
        sent++;
      end
      // every third phase the sender pauses until the block has answered everything
      if (phase_no % 3 == 2) begin
        await_drain();
      end
      phase_no++;
    end

    src_calm  = 1'b0;
    sink_calm = 1'b0;
    await_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
